/* hdl/cbts_pkg.sv */
// ----------------------------------------------------------------------------
// cbts_pkg
// Shared constants, types and helpers of the CAN bit timing search block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbts_pkg;

  localparam int unsigned CLK_W        = 32;
  localparam int unsigned RATE_W       = 20;
  localparam int unsigned PRESC_W      = 30;
  localparam int unsigned SEG1_W       = 4;
  localparam int unsigned SEG2_W       = 3;
  localparam int unsigned SJW_W        = 2;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  localparam int unsigned MAX_QUANTA   = 25;
  localparam int unsigned MIN_QUANTA   = 4;
  localparam int unsigned QUANTA_W     = $clog2(MAX_QUANTA + 1);

  localparam int unsigned BITS_PER_CYC = 2;
  localparam int unsigned DIV_STEPS    = CLK_W / BITS_PER_CYC;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CLK_W-1:0]  CLK_RESET = 32'd36000000;
  localparam logic [SJW_W-1:0]  FIXED_SJW = 2'd2;
  localparam logic [0:0]        REG_CLOCK = 1'b0;

  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CLK_W-1:0]  quotient;
    logic [RATE_W-1:0] remainder;
  } div_rsp_t;

  // (n - 3) / 3 for n from 3 up to 26, as a multiply by 11 and a shift by 5.
  function automatic logic [SEG2_W-1:0] seg_two(input logic [QUANTA_W-1:0] n);
    logic [QUANTA_W-1:0]   x;
    logic [QUANTA_W+3:0]   prod;
    x    = n - QUANTA_W'(3);
    prod = (QUANTA_W + 4)'(x) * (QUANTA_W + 4)'(11);
    return prod[SEG2_W+4:5];
  endfunction

  function automatic logic [SEG1_W-1:0] seg_one(input logic [QUANTA_W-1:0] n);
    logic [QUANTA_W-1:0] x;
    x = n - QUANTA_W'(3);
    return SEG1_W'(x - QUANTA_W'(seg_two(n)));
  endfunction

endpackage

`default_nettype wire

/* hdl/cbts_divider.sv */
// ----------------------------------------------------------------------------
// cbts_divider
// Shared restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbts_divider (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire cbts_pkg::div_req_t req_i,
  output cbts_pkg::div_rsp_t   rsp_o
);

  logic [cbts_pkg::CLK_W-1:0]     acc_q, acc_d;
  logic [cbts_pkg::RATE_W-1:0]    rem_q, rem_d;
  logic [cbts_pkg::RATE_W-1:0]    div_q;
  logic [cbts_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  always_comb begin
    logic [cbts_pkg::RATE_W:0] trial;
    acc_d = acc_q;
    rem_d = rem_q;
    for (int i = 0; i < int'(cbts_pkg::BITS_PER_CYC); i++) begin
      trial = {rem_d, acc_d[cbts_pkg::CLK_W-1]};
      if (trial >= {1'b0, div_q}) begin
        rem_d = cbts_pkg::RATE_W'(trial - {1'b0, div_q});
        acc_d = {acc_d[cbts_pkg::CLK_W-2:0], 1'b1};
      end else begin
        rem_d = trial[cbts_pkg::RATE_W-1:0];
        acc_d = {acc_d[cbts_pkg::CLK_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == cbts_pkg::DIV_CNT_W'(cbts_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = acc_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

/* hdl/cbts_cfg.sv */
// ----------------------------------------------------------------------------
// cbts_cfg
// APB register file holding the peripheral clock frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module cbts_cfg (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [cbts_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [cbts_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cbts_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [cbts_pkg::CLK_W-1:0]         clock_hz_o
);

  logic [cbts_pkg::CLK_W-1:0] clock_q;
  logic                       sel_clock;

  assign sel_clock = (paddr[2] == cbts_pkg::REG_CLOCK);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= cbts_pkg::CLK_RESET;
    end else if (psel && penable && pwrite && sel_clock) begin
      clock_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_clock) begin
      prdata = clock_q;
    end
  end

  assign clock_hz_o = clock_q;

endmodule

`default_nettype wire

/* hdl/can_bit_timing_search.sv */
// ----------------------------------------------------------------------------
// can_bit_timing_search
// Derives CAN bit timing settings for a requested bit rate.
// ----------------------------------------------------------------------------
// A bit rate beat on the input stream starts one search: the peripheral clock
// register is divided by the rate, then quanta counts from 25 down to 4 are
// tried and the count with the smallest remainder wins, an exact fit ending
// the search at once. All divides run on one shared restoring divider that
// retires two bits per cycle. A full search runs 22 trials; a stalled result
// beat holds the next search in its final state until it is taken. The input
// is not ready while a search runs. A zero clock or rate, no usable count,
// or a zero prescaler sets the error flag in tuser.
`default_nettype none

module can_bit_timing_search (
  input  wire         clk_i,
  input  wire         rst_ni,
  // APB configuration port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // [19:0] bit_rate, [23:20] zero
  // Result stream.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [29:0] prescaler_minus_one, [33:30] segment_one, [36:34] segment_two,
  // [38:37] jump_width, [39] zero
  output logic [39:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser    // [0] timing_error
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TOTAL = 3'd1;
  localparam logic [2:0] ST_MODST = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]                          state_q;
  logic [cbts_pkg::CLK_W-1:0]          clock_hz;
  logic [cbts_pkg::CLK_W-1:0]          total_q;
  logic [cbts_pkg::RATE_W-1:0]         best_rem_q;
  logic [cbts_pkg::QUANTA_W-1:0]       n_q;
  logic [cbts_pkg::QUANTA_W-1:0]       chosen_q;
  logic [cbts_pkg::PRESC_W-1:0]        best_quo_q;
  logic                                found_q;
  logic                                out_valid_q;
  logic [cbts_pkg::PRESC_W-1:0]        presc_q;
  logic [cbts_pkg::SEG1_W-1:0]         seg1_q;
  logic [cbts_pkg::SEG2_W-1:0]         seg2_q;
  logic                                err_q;
  logic [cbts_pkg::RATE_W-1:0]         rate;
  logic                                in_beat;
  logic                                out_free;
  cbts_pkg::div_req_t                  div_req;
  cbts_pkg::div_rsp_t                  div_rsp;

  cbts_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .clock_hz_o (clock_hz)
  );

  cbts_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rate          = s_axis_tdata[cbts_pkg::RATE_W-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = clock_hz;
    div_req.divisor  = rate;
    if (state_q == ST_IDLE) begin
      div_req.start = in_beat && (clock_hz != '0) && (rate != '0);
    end else begin
      div_req.start    = (state_q == ST_MODST);
      div_req.dividend = total_q;
      div_req.divisor  = {{(cbts_pkg::RATE_W - cbts_pkg::QUANTA_W){1'b0}}, n_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            found_q <= 1'b0;
            if (div_req.start) begin
              state_q <= ST_TOTAL;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_TOTAL: begin
          if (div_rsp.done) begin
            state_q <= ST_MODST;
          end
        end
        ST_MODST: begin
          state_q <= ST_MOD;
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) begin
              found_q <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              if (div_rsp.remainder < best_rem_q) begin
                found_q <= 1'b1;
              end
              if (n_q == cbts_pkg::QUANTA_W'(cbts_pkg::MIN_QUANTA)) begin
                state_q <= ST_FIN;
              end else begin
                state_q <= ST_MODST;
              end
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        best_rem_q <= rate;
      end
      ST_TOTAL: begin
        if (div_rsp.done) begin
          total_q <= div_rsp.quotient;
          n_q     <= cbts_pkg::QUANTA_W'(cbts_pkg::MAX_QUANTA);
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          if ((div_rsp.remainder == '0) || (div_rsp.remainder < best_rem_q)) begin
            best_rem_q <= div_rsp.remainder;
            chosen_q   <= n_q;
            best_quo_q <= div_rsp.quotient[cbts_pkg::PRESC_W-1:0];
          end
          n_q <= n_q - 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          if (!found_q || (best_quo_q == '0)) begin
            presc_q <= '0;
            seg1_q  <= '0;
            seg2_q  <= '0;
            err_q   <= 1'b1;
          end else begin
            presc_q <= best_quo_q - 1'b1;
            seg1_q  <= cbts_pkg::seg_one(chosen_q);
            seg2_q  <= cbts_pkg::seg_two(chosen_q);
            err_q   <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, cbts_pkg::FIXED_SJW, seg2_q, seg1_q, presc_q};
  assign m_axis_tuser  = err_q;

endmodule

`default_nettype wire

/* hdl/cbts_checker.sv */
// ----------------------------------------------------------------------------
// cbts_checker
// Port-level checks of the CAN bit timing search block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cbts_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser
);

  // A result beat that is stalled holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

  // The input is not ready in the cycle after a beat is taken.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after a beat");

  a_sjw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[38:37] == 2'd2))
    else $error("jump width is not two");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[36:0] == 37'd0))
    else $error("error result carries nonzero timing");

  // Segment one is never shorter than segment two for a valid count.
  a_seg_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[33:30] >= {1'b0, m_axis_tdata[36:34]}))
    else $error("segment one shorter than segment two");

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
